FILE: design/bbr_pkg.sv
// Shared types, constants and command format for the 3x3 RGB box blur.
package bbr_pkg;

  // Line store geometry
  localparam int MAX_WIDTH = 1024;
  localparam int COL_W     = $clog2(MAX_WIDTH);

  // Register and counter widths
  localparam int WIDTH_W    = 11;
  localparam int HEIGHT_W   = 12;
  localparam int PEND_W     = $clog2(MAX_WIDTH + 2);
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 12;

  localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 11'd640;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 12'd480;

  // Configuration register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } cfg_reg_t;

  // Pixel data
  localparam int CHAN_W = 8;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pixel_t;

  localparam int PIX_W = $bits(pixel_t);

  // Mean of nine: sum fits 12 bits, floor(sum/9) = (sum * 7282) >> 16 over that range
  localparam int                SUM_W       = 12;
  localparam int                RECIP_W     = 13;
  localparam logic [RECIP_W-1:0] RECIP_9    = 13'd7282;
  localparam int                RECIP_SHIFT = 16;

  // Work command passed from the front end to the filter pipeline
  typedef struct packed {
    logic             is_drain;   // flush read, no line store write
    logic             src_upper;  // flush read comes from the upper line store
    logic             has_out;    // this command yields a result
    logic             border;     // result is the centre pixel unchanged
    logic             frame_end;  // last result of the frame
    logic [COL_W-1:0] addr;       // line store address
    pixel_t           px;         // incoming pixel
  } cmd_t;

  // Command queue
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

endpackage

FILE: design/bbr_ram.sv
// Generic single-write, single-read RAM with registered read data (read-first).
module bbr_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Storage and read register; a read at the write address returns the old word
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (re) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: design/bbr_front.sv
// Front end: configuration registers, raster position tracking, command generation.
module bbr_front import bbr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_drain,
  input  logic [CHAN_W-1:0]     in_red,
  input  logic [CHAN_W-1:0]     in_green,
  input  logic [CHAN_W-1:0]     in_blue,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  q_full,
  output logic                  q_push,
  output cmd_t                  q_cmd
);

  logic [WIDTH_W-1:0]  width_r;
  logic [HEIGHT_W-1:0] height_r;
  logic [COL_W-1:0]    col_r, col_nxt;
  logic [HEIGHT_W-1:0] row_r, row_nxt;
  logic [PEND_W-1:0]   pend_r, pend_nxt;

  logic [WIDTH_W-1:0]  w_eff, w_m1, drain_idx, col_inc;
  logic [HEIGHT_W-1:0] h_eff, orow;
  logic [COL_W-1:0]    w_last, ocol;
  logic                frame_done, keep, accept, cfg_wr;

  // Effective geometry: zero acts as one, width clamps to the line store size
  always_comb begin
    if (width_r == '0) begin
      w_eff = WIDTH_W'(1);
    end else if (width_r > WIDTH_W'(MAX_WIDTH)) begin
      w_eff = WIDTH_W'(MAX_WIDTH);
    end else begin
      w_eff = width_r;
    end
    h_eff = (height_r == '0) ? HEIGHT_W'(1) : height_r;
  end

  assign w_m1       = w_eff - WIDTH_W'(1);
  assign w_last     = w_m1[COL_W-1:0];
  assign drain_idx  = w_eff - WIDTH_W'(pend_r);
  assign col_inc    = WIDTH_W'(col_r) + WIDTH_W'(1);
  assign frame_done = (row_r >= h_eff);

  // Classify the item and work out the next position
  always_comb begin
    col_nxt          = col_r;
    row_nxt          = row_r;
    pend_nxt         = pend_r;
    keep             = 1'b0;
    orow             = '0;
    ocol             = '0;
    q_cmd            = '0;
    q_cmd.is_drain   = in_drain;
    q_cmd.px.red     = in_red;
    q_cmd.px.green   = in_green;
    q_cmd.px.blue    = in_blue;
    if (in_drain) begin
      // flush: only after the last row, and only while something is pending
      if (frame_done && (pend_r != '0)) begin
        keep            = 1'b1;
        q_cmd.has_out   = 1'b1;
        q_cmd.border    = 1'b1;
        q_cmd.src_upper = (pend_r > PEND_W'(w_eff));
        q_cmd.addr      = q_cmd.src_upper ? w_last : drain_idx[COL_W-1:0];
        pend_nxt        = pend_r - PEND_W'(1);
        if (pend_r == PEND_W'(1)) begin
          q_cmd.frame_end = 1'b1;
          row_nxt         = '0;
          col_nxt         = '0;
        end
      end
    end else if (!frame_done) begin
      keep       = 1'b1;
      q_cmd.addr = col_r;
      if (pend_r <= PEND_W'(w_eff)) begin
        pend_nxt = pend_r + PEND_W'(1);
      end else begin
        // result is for the pixel one row and one column back
        q_cmd.has_out = 1'b1;
        if (col_r != '0) begin
          orow = row_r - HEIGHT_W'(1);
          ocol = col_r - COL_W'(1);
        end else begin
          orow = row_r - HEIGHT_W'(2);
          ocol = w_last;
        end
        q_cmd.border = (orow == '0) || (orow == h_eff - HEIGHT_W'(1)) ||
                       (ocol == '0) || (ocol == w_last);
      end
      if (col_inc >= w_eff) begin
        col_nxt = '0;
        row_nxt = row_r + HEIGHT_W'(1);
      end else begin
        col_nxt = col_inc[COL_W-1:0];
      end
    end
  end

  // Handshakes
  assign in_stall  = q_full;
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign q_push    = accept && keep && !cfg_wr;

  // Registers and position counters; a register write restarts the frame
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      col_r    <= '0;
      row_r    <= '0;
      pend_r   <= '0;
    end else if (cfg_wr) begin
      case (cfg_reg_t'(cfg_index))
        REG_WIDTH: begin
          width_r <= cfg_data[WIDTH_W-1:0];
        end
        REG_HEIGHT: begin
          height_r <= cfg_data[HEIGHT_W-1:0];
        end
        default: begin
        end
      endcase
      col_r  <= '0;
      row_r  <= '0;
      pend_r <= '0;
    end else if (accept) begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      pend_r <= pend_nxt;
    end
  end

endmodule

FILE: design/bbr_fifo.sv
// Short command queue between the front end and the filter pipeline.
module bbr_fifo import bbr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head_cmd,
  output logic full,
  output logic empty
);

  cmd_t                  mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_CNT_W-1:0] count_r;

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + FIFO_PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + FIFO_CNT_W'(1);
        2'b01:   count_r <= count_r - FIFO_CNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

  assign head_cmd = mem_r[rd_ptr_r];
  assign full     = (count_r == FIFO_CNT_W'(FIFO_DEPTH));
  assign empty    = (count_r == '0);

endmodule

FILE: design/bbr_back.sv
// Filter pipeline: line stores, 3x3 window, channel sums, divide by nine, output register.
module bbr_back import bbr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  cmd_t              q_cmd,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CHAN_W-1:0] out_red,
  output logic [CHAN_W-1:0] out_green,
  output logic [CHAN_W-1:0] out_blue,
  output logic              out_frame_end
);

  // floor(sum / 9) by reciprocal multiply
  function automatic logic [CHAN_W-1:0] div9(input logic [SUM_W-1:0] sum);
    logic [SUM_W+RECIP_W-1:0] prod;
    prod = (SUM_W+RECIP_W)'(sum) * (SUM_W+RECIP_W)'(RECIP_9);
    return prod[RECIP_SHIFT +: CHAN_W];
  endfunction

  logic             advance;
  logic [PIX_W-1:0] up_rd, mid_rd;
  pixel_t           up_val, mid_val;
  logic             up_we, mid_we, win_en;

  // stage 1: line store data returned
  logic             s1_valid_r;
  cmd_t             s1_cmd_r;
  logic             fwd_r;
  pixel_t           fwd_px_r;

  // window and stage 2
  pixel_t           win_r [3][3];
  logic             s2_valid_r, s2_has_out_r, s2_is_drain_r, s2_use_mean_r, s2_end_r;
  pixel_t           s2_drain_px_r;
  logic [SUM_W-1:0] sum_red, sum_green, sum_blue;

  // stage 3: sums registered
  logic             s3_valid_r, s3_has_out_r, s3_use_mean_r, s3_end_r;
  pixel_t           s3_pass_r;
  logic [SUM_W-1:0] s3_sum_red_r, s3_sum_green_r, s3_sum_blue_r;

  // output register
  logic             out_valid_r, out_end_r;
  pixel_t           out_px_r;

  // Whole pipeline moves unless a finished result is held at the output
  assign advance = !out_valid_r || !out_stall;
  assign q_pop   = advance && !q_empty;

  // Line stores: middle written on issue, upper takes the old middle word when stage 1 advances
  assign mid_we = q_pop && !q_cmd.is_drain;
  assign up_we  = advance && s1_valid_r && !s1_cmd_r.is_drain;

  bbr_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_mid_store (
    .clk     (clk),
    .we      (mid_we),
    .wr_addr (q_cmd.addr),
    .wr_data (q_cmd.px),
    .re      (q_pop),
    .rd_addr (q_cmd.addr),
    .rd_data (mid_rd)
  );

  bbr_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_up_store (
    .clk     (clk),
    .we      (up_we),
    .wr_addr (s1_cmd_r.addr),
    .wr_data (mid_rd),
    .re      (q_pop),
    .rd_addr (q_cmd.addr),
    .rd_data (up_rd)
  );

  // Upper read that collided with the pending upper write takes the written word
  assign up_val  = fwd_r ? fwd_px_r : pixel_t'(up_rd);
  assign mid_val = pixel_t'(mid_rd);
  assign win_en  = up_we;

  // Stage 1 control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fwd_r      <= 1'b0;
    end else if (advance) begin
      s1_valid_r <= q_pop;
      fwd_r      <= q_pop && up_we && (q_cmd.addr == s1_cmd_r.addr);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_cmd_r <= q_cmd;
      fwd_px_r <= mid_val;
    end
  end

  // Window shift: new column is upper, middle, incoming
  always_ff @(posedge clk) begin
    if (win_en) begin
      for (int r = 0; r < 3; r++) begin
        win_r[r][0] <= win_r[r][1];
        win_r[r][1] <= win_r[r][2];
      end
      win_r[0][2] <= up_val;
      win_r[1][2] <= mid_val;
      win_r[2][2] <= s1_cmd_r.px;
    end
  end

  // Stage 2 registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (advance) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_has_out_r  <= s1_cmd_r.has_out;
      s2_is_drain_r <= s1_cmd_r.is_drain;
      s2_use_mean_r <= !s1_cmd_r.is_drain && s1_cmd_r.has_out && !s1_cmd_r.border;
      s2_end_r      <= s1_cmd_r.frame_end;
      s2_drain_px_r <= s1_cmd_r.src_upper ? up_val : mid_val;
    end
  end

  // Channel sums over the window
  always_comb begin
    sum_red   = '0;
    sum_green = '0;
    sum_blue  = '0;
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        sum_red   = sum_red   + SUM_W'(win_r[r][k].red);
        sum_green = sum_green + SUM_W'(win_r[r][k].green);
        sum_blue  = sum_blue  + SUM_W'(win_r[r][k].blue);
      end
    end
  end

  // Stage 3 registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (advance) begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s3_has_out_r   <= s2_has_out_r;
      s3_use_mean_r  <= s2_use_mean_r;
      s3_end_r       <= s2_end_r;
      s3_pass_r      <= s2_is_drain_r ? s2_drain_px_r : win_r[1][1];
      s3_sum_red_r   <= sum_red;
      s3_sum_green_r <= sum_green;
      s3_sum_blue_r  <= sum_blue;
    end
  end

  // Output register: divide by nine or pass the centre pixel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s3_valid_r && s3_has_out_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s3_valid_r && s3_has_out_r) begin
      out_end_r <= s3_end_r;
      if (s3_use_mean_r) begin
        out_px_r.red   <= div9(s3_sum_red_r);
        out_px_r.green <= div9(s3_sum_green_r);
        out_px_r.blue  <= div9(s3_sum_blue_r);
      end else begin
        out_px_r <= s3_pass_r;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_red       = out_px_r.red;
  assign out_green     = out_px_r.green;
  assign out_blue      = out_px_r.blue;
  assign out_frame_end = out_end_r;

endmodule

FILE: design/box_blur_3x3_rgb_unit.sv
// Top level of the streaming 3x3 RGB box blur.
//
//   port group | direction | handshake           | payload
//   in_*       | input     | in_valid / in_stall | in_drain, in_red, in_green, in_blue
//   out_*      | output    | out_valid/out_stall | out_red, out_green, out_blue, out_frame_end
//   cfg_*      | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One item per clock while out_stall is low: one store read port each, used once per item.
// A result passes the command queue, the stage registers and the output register, and
// leaves one image row plus one pixel of input after the pixel it describes.
// Reset (rst_n low, synchronous) clears counters and pipeline; line stores need no clearing.
// out_stall holds the whole pipeline; the four-entry command queue absorbs input
// until it fills, and only then is in_stall raised.
module box_blur_3x3_rgb_unit import bbr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_drain,
  input  logic [CHAN_W-1:0]     in_red,
  input  logic [CHAN_W-1:0]     in_green,
  input  logic [CHAN_W-1:0]     in_blue,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [CHAN_W-1:0]     out_red,
  output logic [CHAN_W-1:0]     out_green,
  output logic [CHAN_W-1:0]     out_blue,
  output logic                  out_frame_end,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic q_push, q_pop, q_full, q_empty;
  cmd_t push_cmd, head_cmd;

  // Position tracking and command generation
  bbr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_drain  (in_drain),
    .in_red    (in_red),
    .in_green  (in_green),
    .in_blue   (in_blue),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  // Command queue
  bbr_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .full     (q_full),
    .empty    (q_empty)
  );

  // Filter pipeline
  bbr_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_cmd         (head_cmd),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .out_frame_end (out_frame_end)
  );

endmodule

FILE: design/bbr_checker.sv
// Port-level checks for the box blur top level, bound in from here.
module bbr_checker import bbr_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [CHAN_W-1:0]     out_red,
  input logic [CHAN_W-1:0]     out_green,
  input logic [CHAN_W-1:0]     out_blue,
  input logic                  out_frame_end
);

  // A held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // A held result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_red) && $stable(out_green) &&
                               $stable(out_blue) && $stable(out_frame_end))
    else $error("result payload changed while stalled");

  // Reset leaves no result offered and the input open
  a_rst_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("pipeline not clear after reset");

  // With the output side free the queue drains, so input stall is released in the next cycle
  a_stall_release: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall && !out_stall |=> !in_stall)
    else $error("input stalled although output side is free");

endmodule

bind box_blur_3x3_rgb_unit bbr_checker u_bbr_checker (.*);
